>>> src/rotary_dial_combination_lock_unit_assert.svh
// Assertion macros shared by the lock RTL.
// Each macro expects clk and arst_n to exist in the module that uses it.
`ifndef ROTARY_DIAL_COMBINATION_LOCK_UNIT_ASSERT_SVH
`define ROTARY_DIAL_COMBINATION_LOCK_UNIT_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define RDCL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define RDCL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/rdcl_pkg.sv
package rdcl_pkg;

	localparam int unsigned KEY_COUNT = 4;
	localparam int unsigned DIGIT_W = 4;
	localparam int unsigned CFG_IDX_W = $clog2(KEY_COUNT);
	localparam int unsigned STAGE_W = 3;
	localparam int unsigned QUARTER_W = 6;
	localparam int unsigned POS_W = 2;

	localparam logic [STAGE_W-1:0] STAGE_IDLE = 3'd0;
	localparam logic [STAGE_W-1:0] STAGE_FIRST = 3'd1;
	localparam logic [STAGE_W-1:0] STAGE_LAST_ENTRY = 3'd4;
	localparam logic [STAGE_W-1:0] STAGE_DONE = 3'd5;

	// Dial position in quarter steps: 9.75 is the last count before the wrap.
	localparam logic [QUARTER_W-1:0] QUARTERS_LAST = 6'd39;

	typedef logic [DIGIT_W-1:0] digit_t;
	typedef logic [KEY_COUNT-1:0][DIGIT_W-1:0] digit_arr_t;

	typedef struct packed {
		logic [STAGE_W-1:0] entry_stage;
		digit_t shown_digit;
		logic [POS_W-1:0] shown_position;
		logic display_update;
		logic entry_complete;
		logic code_match;
	} result_t;

endpackage

>>> src/rdcl_key_regs.sv
module rdcl_key_regs (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [rdcl_pkg::CFG_IDX_W-1:0] cfg_index,
	input rdcl_pkg::digit_t cfg_data,
	output rdcl_pkg::digit_arr_t keys
);
	import rdcl_pkg::*;

	digit_arr_t keys_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keys_q <= '0;
		end else if (cfg_we) begin
			keys_q[cfg_index] <= cfg_data;
		end
	end

	assign keys = keys_q;

endmodule

>>> src/rdcl_core.sv
module rdcl_core (
	input logic clk,
	input logic arst_n,
	input logic step_en,
	input logic clk_level,
	input logic dt_level,
	input rdcl_pkg::digit_arr_t keys,
	output rdcl_pkg::result_t res
);
	import rdcl_pkg::*;

	logic clock_prev_q;
	logic cw_q;
	logic ccw_q;
	logic [STAGE_W-1:0] stage_q;
	logic [QUARTER_W-1:0] quarter_q;
	digit_t last_digit_q;
	digit_arr_t captured_q;

	logic cw_d;
	logic ccw_d;
	logic [STAGE_W-1:0] stage_d;
	logic [QUARTER_W-1:0] quarter_d;
	digit_t last_digit_d;
	digit_arr_t captured_d;
	logic update_d;
	logic want_cw;
	logic fwd;
	logic rev;
	logic [QUARTER_W-1:0] quarter_inc;
	logic [STAGE_W-1:0] slot_full;
	logic [STAGE_W-1:0] pos_full;
	logic in_entry_d;
	logic complete_d;

	always_comb begin
		cw_d = cw_q;
		ccw_d = ccw_q;
		stage_d = stage_q;
		quarter_d = quarter_q;
		last_digit_d = last_digit_q;
		captured_d = captured_q;
		update_d = 1'b0;

		// A rising edge on the encoder clock line latches the turn direction.
		if (!clock_prev_q && clk_level) begin
			cw_d = dt_level;
			ccw_d = ~dt_level;
		end

		want_cw = stage_q[0];
		fwd = want_cw ? cw_d : ccw_d;
		rev = want_cw ? ccw_d : cw_d;
		quarter_inc = (quarter_q == QUARTERS_LAST) ? '0 : quarter_q + 6'd1;
		slot_full = stage_q - STAGE_FIRST;

		priority if (stage_q == STAGE_IDLE) begin
			if (cw_d && !ccw_d) begin
				stage_d = STAGE_FIRST;
				quarter_d = '0;
				last_digit_d = '0;
			end
		end else if (stage_q <= STAGE_LAST_ENTRY) begin
			if (fwd) begin
				quarter_d = quarter_inc;
				if (quarter_inc[QUARTER_W-1:2] != last_digit_q) begin
					last_digit_d = quarter_inc[QUARTER_W-1:2];
					update_d = 1'b1;
				end
			end else if (rev) begin
				captured_d[slot_full[POS_W-1:0]] = last_digit_q;
				stage_d = stage_q + 3'd1;
				quarter_d = '0;
				last_digit_d = '0;
			end
		end else begin
			stage_d = stage_q;
		end

		in_entry_d = (stage_d >= STAGE_FIRST) && (stage_d <= STAGE_LAST_ENTRY);
		complete_d = (stage_d >= STAGE_DONE);
		pos_full = stage_d - STAGE_FIRST;

		res.entry_stage = stage_d;
		res.shown_digit = last_digit_d;
		res.shown_position = in_entry_d ? pos_full[POS_W-1:0] : '0;
		res.display_update = update_d;
		res.entry_complete = complete_d;
		res.code_match = complete_d && (captured_d == keys);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_prev_q <= 1'b0;
			cw_q <= 1'b0;
			ccw_q <= 1'b0;
			stage_q <= STAGE_IDLE;
			quarter_q <= '0;
			last_digit_q <= '0;
			captured_q <= '0;
		end else if (step_en) begin
			clock_prev_q <= clk_level;
			cw_q <= cw_d;
			ccw_q <= ccw_d;
			stage_q <= stage_d;
			quarter_q <= quarter_d;
			last_digit_q <= last_digit_d;
			captured_q <= captured_d;
		end
	end

endmodule

>>> src/rotary_dial_combination_lock_unit.sv
// Channel   Handshake               Payload
// in        in_valid / in_ready     clk_level, dt_level
// out       out_valid / out_ready   entry_stage, shown_digit, shown_position,
//                                   display_update, entry_complete, code_match
// cfg       cfg_we                  cfg_index, cfg_data
//
// One transaction is accepted per cycle while in_ready is high; s1 holds it, s2 its result.
// The sequencer state updates in the cycle the input register hands its item on.
// Reset clears the sequencer, the key registers and both pipeline valid flags.
// While out_ready is low the result holds and an empty input register takes one transaction.
module rotary_dial_combination_lock_unit (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic clk_level,
	input logic dt_level,
	output logic out_valid,
	input logic out_ready,
	output logic [rdcl_pkg::STAGE_W-1:0] entry_stage,
	output rdcl_pkg::digit_t shown_digit,
	output logic [rdcl_pkg::POS_W-1:0] shown_position,
	output logic display_update,
	output logic entry_complete,
	output logic code_match,
	input logic cfg_we,
	input logic [rdcl_pkg::CFG_IDX_W-1:0] cfg_index,
	input rdcl_pkg::digit_t cfg_data
);
	import rdcl_pkg::*;
	`include "rotary_dial_combination_lock_unit_assert.svh"

	logic valid_s1;
	logic clk_level_s1;
	logic dt_level_s1;
	logic valid_s2;
	result_t res_s2;
	result_t res_next;
	digit_arr_t keys;
	logic adv_s1;
	logic fire_s1;

	assign adv_s1 = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || adv_s1;
	assign fire_s1 = valid_s1 && adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv_s1) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			clk_level_s1 <= clk_level;
			dt_level_s1 <= dt_level;
		end
		if (fire_s1) begin
			res_s2 <= res_next;
		end
	end

	rdcl_key_regs u_keys (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.keys(keys)
	);

	rdcl_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.step_en(fire_s1),
		.clk_level(clk_level_s1),
		.dt_level(dt_level_s1),
		.keys(keys),
		.res(res_next)
	);

	assign out_valid = valid_s2;
	assign entry_stage = res_s2.entry_stage;
	assign shown_digit = res_s2.shown_digit;
	assign shown_position = res_s2.shown_position;
	assign display_update = res_s2.display_update;
	assign entry_complete = res_s2.entry_complete;
	assign code_match = res_s2.code_match;

	`RDCL_ASSERT_NOW(a_complete_stage, valid_s2, entry_complete == (entry_stage >= STAGE_DONE), "completion flag disagrees with stage")
	`RDCL_ASSERT_NOW(a_match_needs_complete, valid_s2 && code_match, entry_complete, "match reported before entry is complete")
	`RDCL_ASSERT_NOW(a_update_in_entry, valid_s2 && display_update, (entry_stage >= STAGE_FIRST) && (entry_stage <= STAGE_LAST_ENTRY), "display update outside digit entry")
	`RDCL_ASSERT_NEXT(a_s1_holds_on_stall, valid_s1 && !adv_s1, valid_s1 && $stable(clk_level_s1) && $stable(dt_level_s1), "input register lost a stalled transaction")

endmodule
